### src/bls_pkg.sv
// Shared types and default sizes for the bounded list sorter.
// Used by bls_ctrl, bls_datapath and bounded_list_sorter; depends on nothing.
`default_nettype none

package bls_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Controller phases: taking in list words, then streaming the sorted list out.
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;     // place the incoming word into the sorted row
    logic mark_drop;  // incoming word found the row full
    logic shift_out;  // head word taken, move the row up by one
    logic clear_drop; // list finished, clear the drop flag
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // every cell holds a word
    logic one_left;   // exactly one word remains
  } status_t;

endpackage

`default_nettype wire

### src/bls_ctrl.sv
// Controller state machine of the bounded list sorter.
// Depends on bls_pkg for the state, command and status types.
`default_nettype none

module bls_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire bls_pkg::status_t status,
  output bls_pkg::cmd_t        cmd
);

  bls_pkg::state_t state;
  bls_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bls_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bls_pkg::ST_LOAD: begin
        if (in_valid && last) begin
          state_next = bls_pkg::ST_EMIT;
        end
      end
      bls_pkg::ST_EMIT: begin
        if (!out_stall && status.one_left) begin
          state_next = bls_pkg::ST_LOAD;
        end
      end
      default: state_next = bls_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      bls_pkg::ST_LOAD: begin
        in_stall       = 1'b0;
        cmd.insert     = in_valid && !status.full;
        cmd.mark_drop  = in_valid && status.full;
      end
      bls_pkg::ST_EMIT: begin
        out_valid      = 1'b1;
        cmd.shift_out  = !out_stall;
        cmd.clear_drop = !out_stall && status.one_left;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/bls_datapath.sv
// Datapath of the bounded list sorter: a row of sorted cells, word count and drop flag.
// Depends on bls_pkg for the command and status types.
`default_nettype none

module bls_datapath #(
  parameter int CAPACITY    = bls_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bls_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bls_pkg::cmd_t                 cmd,
  input  wire logic signed [VALUE_WIDTH-1:0] value_in,
  output logic signed [VALUE_WIDTH-1:0]      head_value,
  output logic                               drop_flag,
  output bls_pkg::status_t                   status
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_WIDTH-1:0] cells      [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cells_next [CAPACITY];
  logic [CAPACITY-1:0]           above;
  logic [CW-1:0]                 count;
  logic                          drop;

  // A cell is above the new word if it holds a word greater than it; the row
  // stays sorted, so these cells form one run at the tail of the filled part.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      above[i] = (CW'(i) < count) && (cells[i] > value_in);
    end
  end

  always_comb begin
    cells_next = cells;
    if (cmd.shift_out) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cells_next[i] = cells[i + 1];
      end
    end else if (cmd.insert) begin
      if (above[0] || count == '0) begin
        cells_next[0] = value_in;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (above[i - 1]) begin
          cells_next[i] = cells[i - 1];
        end else if (above[i] || CW'(i) == count) begin
          cells_next[i] = value_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + CW'(1);
      end else if (cmd.shift_out) begin
        count <= count - CW'(1);
      end
      if (cmd.mark_drop) begin
        drop <= 1'b1;
      end else if (cmd.clear_drop) begin
        drop <= 1'b0;
      end
    end
  end

  assign head_value      = cells[0];
  assign drop_flag       = drop;
  assign status.full     = (count == CW'(CAPACITY));
  assign status.one_left = (count == CW'(1));

endmodule

`default_nettype wire

### src/bounded_list_sorter.sv
// Top level of the bounded list sorter: ties the controller to the datapath.
// Depends on bls_pkg, bls_ctrl and bls_datapath.
`default_nettype none

// The sorter takes a list of signed words, one word per input transfer, and
// keeps them in a row of CAPACITY cells that is always in non-decreasing
// order: each arriving word is slotted into place in the cycle it is taken,
// so loading runs at one word per clock with in_stall low. The word that
// carries last is itself part of the list and closes it; from the next cycle
// the block streams the list out, smallest first, one word per clock while
// out_stall is low, marking the final word with last_out. Input is stalled
// for the whole of that output phase. Words that arrive while all CAPACITY
// cells are full are discarded, and every output word of that list then
// carries dropped. Once the final word has been taken the count and the
// drop flag are clear and the next list may begin. The insertion compares
// of all cells run side by side, so the critical path is one VALUE_WIDTH-bit
// signed compare and a three-way select.
module bounded_list_sorter #(
  parameter int CAPACITY    = bls_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bls_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0]      sorted_value,
  output logic                               last_out,
  output logic                               dropped
);

  bls_pkg::cmd_t    cmd;
  bls_pkg::status_t status;

  // The controller decides when words move in and out; the datapath holds
  // the sorted row and reports when it is full or down to its last word.
  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bls_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value_in   (value),
    .head_value (sorted_value),
    .drop_flag  (dropped),
    .status     (status)
  );

  // The head of the row is the next word out; the final word is the one
  // left alone in the row.
  assign last_out = status.one_left;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("input taken while output phase active");

  // A closing word always starts an output phase.
  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last) |=> out_valid)
    else $error("closed list not emitted");

  // After the final word is taken the block returns to loading.
  a_end_of_list: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_out) |=> (!out_valid && !in_stall && !dropped))
    else $error("block did not return to loading after final word");

  // Within a list, output keeps coming until the final word.
  a_list_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_out) |=> out_valid)
    else $error("output phase ended before final word");

endmodule

`default_nettype wire
